>>> design/skprs_pkg.sv
// Shared types and constants for the sorted key pair range search.
// Holds field widths, state encoding and the key biasing function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skprs_pkg;

    localparam int SLOT_W      = 10;
    localparam int GROUP_W     = 32;
    localparam int ORDER_W     = 48;
    localparam int KEY_W       = GROUP_W + ORDER_W;
    localparam int POS_W       = 11;
    localparam int IN_TDATA_W  = 256;
    localparam int OUT_TDATA_W = 24;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HOLD
    } state_t;

    // sign bits flipped so that an unsigned compare of {group, order} is lexicographic
    function automatic key_t bias_key(input logic [GROUP_W-1:0] group,
                                      input logic [ORDER_W-1:0] order);
        key_t k;
        k = {group ^ {1'b1, {(GROUP_W-1){1'b0}}}, order ^ {1'b1, {(ORDER_W-1){1'b0}}}};
        return k;
    endfunction

endpackage

`default_nettype wire

>>> design/skprs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Width and depth set by parameters. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module skprs_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/sorted_key_pair_range_search.sv
// Top level of the sorted key pair range search.
// Depends on skprs_pkg and skprs_ram (key table memory).
//
// Holds a table of (group, order) keys, loaded slot by slot with mode 0 requests
// and sorted by the user. A mode 1 request returns the lexicographic lower bound of
// the range start and the upper bound of the range end over the first entry_count
// slots. A query runs two bisections one after the other, each probe one read of the
// single key memory, with at most floor(log2(n)) + 1 probes per search for
// n = min(entry_count, TABLE_DEPTH). Requests are accepted while a finished result
// still waits on the output register.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_pair_range_search
    import skprs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // config
    input  wire logic                   cfg_wr_en,
    input  wire logic [POS_W-1:0]       cfg_wr_data,  // entry_count
    // requests
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // slot, entry_group, entry_order, low_group, low_order, high_group, high_order
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [0:0]             s_tuser,      // mode
    // results
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata       // first_position, end_position
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    localparam int SLOT_LSB   = 0;
    localparam int EGROUP_LSB = SLOT_LSB + SLOT_W;
    localparam int EORDER_LSB = EGROUP_LSB + GROUP_W;
    localparam int LGROUP_LSB = EORDER_LSB + ORDER_W;
    localparam int LORDER_LSB = LGROUP_LSB + GROUP_W;
    localparam int HGROUP_LSB = LORDER_LSB + ORDER_W;
    localparam int HORDER_LSB = HGROUP_LSB + GROUP_W;

    state_t state_reg, state_next;

    logic              s_accept;
    logic              query_accept;
    logic              load_en;
    logic [SLOT_W-1:0] in_slot;
    pos_t              entry_count_reg;
    pos_t              count_sat;

    key_t low_key_reg, high_key_reg;
    logic upper_reg;
    logic pend_reg;
    pos_t lo_reg, hi_reg, mid_reg, cnt_reg;
    pos_t first_reg, end_reg;

    key_t search_key;
    key_t rd_data;
    logic go_right;
    pos_t lo_c, hi_c, mid_c;
    logic search_done;
    logic rd_en;
    logic hold_load;

    logic m_valid_reg;
    pos_t m_first_reg, m_end_reg;

    assign in_slot      = s_tdata[SLOT_LSB +: SLOT_W];
    assign s_accept     = s_tvalid && s_tready;
    assign query_accept = s_accept && (s_tuser[0] == MODE_QUERY);
    assign load_en      = s_accept && (s_tuser[0] == MODE_LOAD)
                          && (32'(in_slot) < TABLE_DEPTH);

    assign count_sat = (32'(entry_count_reg) > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH)
                                                            : entry_count_reg;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_wr_en) begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    skprs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (load_en),
        .wr_addr (ADDR_W'(in_slot)),
        .wr_data (bias_key(s_tdata[EGROUP_LSB +: GROUP_W], s_tdata[EORDER_LSB +: ORDER_W])),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(mid_c)),
        .rd_data (rd_data)
    );

    // bisection step: resolve the probe returned this cycle, then pick the next one
    always_comb begin
        search_key = upper_reg ? high_key_reg : low_key_reg;
        go_right   = upper_reg ? (rd_data <= search_key) : (rd_data < search_key);
        lo_c       = lo_reg;
        hi_c       = hi_reg;
        if (pend_reg) begin
            if (go_right) begin
                lo_c = mid_reg + pos_t'(1);
            end else begin
                hi_c = mid_reg;
            end
        end
        mid_c       = lo_c + ((hi_c - lo_c) >> 1);
        search_done = !(lo_c < hi_c);
    end

    // fsm outputs
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        rd_en     = (state_reg == ST_SEARCH) && !search_done;
        hold_load = (state_reg == ST_HOLD) && (!m_valid_reg || m_tready);
    end

    // fsm next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (query_accept) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (search_done && upper_reg) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (hold_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            upper_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (query_accept) begin
                pend_reg  <= 1'b0;
                upper_reg <= 1'b0;
            end else if (state_reg == ST_SEARCH) begin
                pend_reg <= rd_en;
                if (search_done) begin
                    upper_reg <= 1'b1;
                end
            end
        end
    end

    // search datapath
    always_ff @(posedge aclk) begin
        if (query_accept) begin
            low_key_reg  <= bias_key(s_tdata[LGROUP_LSB +: GROUP_W],
                                     s_tdata[LORDER_LSB +: ORDER_W]);
            high_key_reg <= bias_key(s_tdata[HGROUP_LSB +: GROUP_W],
                                     s_tdata[HORDER_LSB +: ORDER_W]);
            lo_reg       <= '0;
            hi_reg       <= count_sat;
            cnt_reg      <= count_sat;
        end else if (state_reg == ST_SEARCH) begin
            mid_reg <= mid_c;
            if (search_done && !upper_reg) begin
                first_reg <= lo_c;
                lo_reg    <= '0;
                hi_reg    <= cnt_reg;
            end else begin
                lo_reg <= lo_c;
                hi_reg <= hi_c;
                if (search_done) begin
                    end_reg <= lo_c;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (hold_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_load) begin
            m_first_reg <= first_reg;
            m_end_reg   <= end_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 2*POS_W){1'b0}}, m_end_reg, m_first_reg};

    // a query always starts a search
    assert property (@(posedge aclk) disable iff (!aresetn)
        query_accept |=> (state_reg == ST_SEARCH))
        else $error("query accepted without starting a search");

    // bisection bounds stay ordered
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (lo_reg <= hi_reg) && (hi_reg <= cnt_reg))
        else $error("bisection bounds out of order");

    // both positions lie within the searched count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> (first_reg <= cnt_reg) && (end_reg <= cnt_reg))
        else $error("result position beyond entry count");

endmodule

`default_nettype wire
